@@ sv/npz_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, types and step functions for the neutrino pz solver.
package npz_pkg;

	localparam int FRAC_BITS = 4;
	localparam int W_MASS_W = 12;
	localparam logic [W_MASS_W-1:0] W_MASS_RESET = 12'd1286;

	localparam int IN_W = 17;
	localparam int E_W = 16;
	localparam int OUT_W = 24;

	localparam int ALPHA_W = 36;
	localparam int A_W = 34;
	localparam int B_W = 53;
	localparam int INNER_W = 70;
	localparam int HALF_W = INNER_W / 2;

	localparam int RAD_W = 102;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 3;

	// roots below 1e-6 in 2^-(3*FRAC_BITS) units count as zero
	localparam int S_THRESH = ((1 << (3 * FRAC_BITS)) + 999999) / 1000000;

	localparam int NUMS_W = 55;
	localparam int NUM_W = NUMS_W - 1;
	localparam int DENS_W = A_W + 1;
	localparam int DEN_W = DENS_W - 1;
	localparam int DREM_W = DEN_W + 1;
	localparam int DIV_LAT = NUM_W + 2;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_ONE   = 2'd1,
		ST_TWO   = 2'd2,
		ST_DEGEN = 2'd3
	} status_t;

	typedef struct packed {
		logic degen;
		logic noroot;
		logic signed [B_W-1:0] b;
		logic signed [A_W-1:0] a;
	} sq_meta_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_step_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic qbit;
	} div_step_t;

	// one restoring square-root digit
	function automatic sq_step_t sqrt_step(input logic [REM_W-1:0] rem,
		input logic [ROOT_W-1:0] root, input logic [1:0] pair);
		logic [REM_W-1:0] rs;
		logic [REM_W-1:0] tr;
		sq_step_t r;
		rs = {rem[REM_W-3:0], pair};
		tr = {1'b0, root, 2'b01};
		if (rs >= tr) begin
			r.rem = rs - tr;
			r.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = rs;
			r.root = {root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// one restoring division bit
	function automatic div_step_t div_step(input logic [DREM_W-1:0] rem,
		input logic [DEN_W-1:0] den, input logic nbit);
		logic [DREM_W-1:0] rs;
		div_step_t r;
		rs = {rem[DREM_W-2:0], nbit};
		if (rs >= {1'b0, den}) begin
			r.rem = rs - {1'b0, den};
			r.qbit = 1'b1;
		end else begin
			r.rem = rs;
			r.qbit = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ sv/npz_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, side data alongside.
module npz_sqrt_pipe import npz_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [RAD_W-1:0] in_rad,
	input  sq_meta_t in_meta,
	output logic out_valid,
	output logic [ROOT_W-1:0] out_root,
	output sq_meta_t out_meta
);

	logic v_s [ROOT_W];
	logic [REM_W-1:0] rem_s [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0] rad_s [ROOT_W];
	sq_meta_t meta_s [ROOT_W];

	sq_step_t nxt [ROOT_W];
	logic [RAD_W-1:0] rad_src [ROOT_W];

	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			if (k == 0) begin
				rad_src[k] = in_rad;
				nxt[k] = sqrt_step('0, '0, in_rad[RAD_W-1 -: 2]);
			end else begin
				rad_src[k] = rad_s[k-1];
				nxt[k] = sqrt_step(rem_s[k-1], root_s[k-1], rad_s[k-1][RAD_W-1 -: 2]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) v_s[k] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int k = 1; k < ROOT_W; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		meta_s[0] <= in_meta;
		for (int k = 0; k < ROOT_W; k++) begin
			rem_s[k] <= nxt[k].rem;
			root_s[k] <= nxt[k].root;
			rad_s[k] <= {rad_src[k][RAD_W-3:0], 2'b00};
		end
		for (int k = 1; k < ROOT_W; k++) meta_s[k] <= meta_s[k-1];
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];
	assign out_meta = meta_s[ROOT_W-1];

endmodule

@@ sv/npz_div_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined signed division truncated toward zero, one quotient bit per stage.
module npz_div_pipe import npz_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [NUMS_W-1:0] in_num,
	input  logic signed [DENS_W-1:0] in_den,
	output logic out_valid,
	output logic signed [NUMS_W-1:0] out_quot
);

	logic v_s0;
	logic neg_s0;
	logic [NUM_W-1:0] num_s0;
	logic [DEN_W-1:0] den_s0;

	logic v_s [NUM_W];
	logic neg_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [DREM_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s [NUM_W];

	logic v_q;
	logic signed [NUMS_W-1:0] quot_q;

	logic signed [NUMS_W-1:0] num_abs;
	logic signed [DENS_W-1:0] den_abs;
	div_step_t nxt [NUM_W];
	logic [NUM_W-1:0] nq_src [NUM_W];

	assign num_abs = in_num[NUMS_W-1] ? -in_num : in_num;
	assign den_abs = in_den[DENS_W-1] ? -in_den : in_den;

	// nq holds the dividend bits still to use at the top, quotient bits at the bottom
	always_comb begin
		for (int k = 0; k < NUM_W; k++) begin
			if (k == 0) begin
				nq_src[k] = num_s0;
				nxt[k] = div_step('0, den_s0, num_s0[NUM_W-1]);
			end else begin
				nq_src[k] = nq_s[k-1];
				nxt[k] = div_step(rem_s[k-1], den_s[k-1], nq_s[k-1][NUM_W-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_q <= 1'b0;
			for (int k = 0; k < NUM_W; k++) v_s[k] <= 1'b0;
		end else begin
			v_s0 <= in_valid;
			v_q <= v_s[NUM_W-1];
			v_s[0] <= v_s0;
			for (int k = 1; k < NUM_W; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		neg_s0 <= in_num[NUMS_W-1] ^ in_den[DENS_W-1];
		num_s0 <= num_abs[NUM_W-1:0];
		den_s0 <= den_abs[DEN_W-1:0];
		den_s[0] <= den_s0;
		neg_s[0] <= neg_s0;
		for (int k = 0; k < NUM_W; k++) begin
			rem_s[k] <= nxt[k].rem;
			nq_s[k] <= {nq_src[k][NUM_W-2:0], nxt[k].qbit};
		end
		for (int k = 1; k < NUM_W; k++) begin
			den_s[k] <= den_s[k-1];
			neg_s[k] <= neg_s[k-1];
		end
		quot_q <= neg_s[NUM_W-1] ? -$signed({1'b0, nq_s[NUM_W-1]})
			: $signed({1'b0, nq_s[NUM_W-1]});
	end

	assign out_valid = v_q;
	assign out_quot = quot_q;

endmodule

@@ sv/neutrino_pz_w_mass_solver_top.sv @@
`timescale 1ns / 1ps
// Pipeline from start to result_valid: 6 setup stages including the input products,
// 51 root stages, 1 numerator stage, 56 divider stages, 1 output register.
// Throughput: one event per cycle; busy is always low, the chain never stalls.
// Each root bit and each quotient bit is one pipeline stage, which sets the depth.
// Reset (arst_n low, asynchronous) clears all valid bits and sets w_mass to 1286.
module neutrino_pz_w_mass_solver_top import npz_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [IN_W-1:0] lepton_px,
	input  logic signed [IN_W-1:0] lepton_py,
	input  logic signed [IN_W-1:0] lepton_pz,
	input  logic [E_W-1:0] lepton_energy,
	input  logic signed [IN_W-1:0] met_x,
	input  logic signed [IN_W-1:0] met_y,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [W_MASS_W-1:0] cfg_data,
	output logic result_valid,
	output logic [1:0] root_status,
	output logic signed [OUT_W-1:0] pz_first,
	output logic signed [OUT_W-1:0] pz_second,
	output logic saturated
);

	localparam logic signed [NUMS_W-1:0] ROOT_MAX = NUMS_W'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [NUMS_W-1:0] ROOT_MIN = -NUMS_W'(2 ** (OUT_W - 1));

	logic [W_MASS_W-1:0] w_mass_q;

	// stage 1: products
	logic v_s1;
	logic [23:0] mw2_s1;
	logic signed [33:0] pxmx_s1, pymy_s1;
	logic [32:0] pz2_s1, mx2_s1, my2_s1;
	logic [31:0] e2_s1;
	logic signed [IN_W-1:0] pz_s1;
	// stage 2: alpha, a, t
	logic v_s2;
	logic signed [ALPHA_W-1:0] alpha_s2;
	logic signed [A_W-1:0] a_s2;
	logic [33:0] t_s2;
	logic [31:0] e2_s2;
	logic signed [IN_W-1:0] pz_s2;
	// stage 3: b, alpha^2, 4*t*|a|
	logic v_s3;
	logic signed [B_W-1:0] b_s3;
	logic [INNER_W-1:0] p_s3;
	logic [67:0] q_s3;
	logic signed [A_W-1:0] a_s3;
	logic [31:0] e2_s3;
	// stage 4: inner term
	logic v_s4;
	logic [INNER_W-1:0] inner_s4;
	logic [31:0] e2_s4;
	sq_meta_t meta_s4;
	// stage 5/6: discriminant
	logic v_s5, v_s6;
	logic [66:0] pp0_s5, pp1_s5;
	sq_meta_t meta_s5, meta_s6;
	logic [RAD_W-1:0] rad_s6;
	// stage 7: numerators
	logic v_s7;
	logic signed [NUMS_W-1:0] num1_s7, num2_s7;
	logic signed [DENS_W-1:0] den_s7;
	status_t status_s7;

	status_t stat_d [DIV_LAT];

	logic result_valid_q;
	status_t status_q;
	logic signed [OUT_W-1:0] first_q, second_q;
	logic sat_q;

	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	sq_meta_t sq_meta;
	logic d1_valid, d2_valid;
	logic signed [NUMS_W-1:0] d1_quot, d2_quot;

	logic signed [34:0] pq_sum;
	logic [ALPHA_W-2:0] abs_alpha;
	logic [A_W-2:0] abs_a;
	logic [65:0] ta_prod;
	logic [INNER_W-1:0] inner_nx;
	logic noroot_nx;
	sq_meta_t meta_nx;
	logic signed [NUMS_W-1:0] nb;
	logic [ROOT_W-1:0] s_eff;
	status_t status_nx;
	logic signed [OUT_W-1:0] c1, c2;
	logic s1f, s2f;
	logic roots;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_mass_q <= W_MASS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			w_mass_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= sq_valid;
			result_valid_q <= d1_valid;
		end
	end

	assign pq_sum = 35'(pxmx_s1) + 35'(pymy_s1);
	assign abs_alpha = alpha_s2[ALPHA_W-1] ? (ALPHA_W-1)'(-alpha_s2) : (ALPHA_W-1)'(alpha_s2);
	assign abs_a = a_s2[A_W-1] ? (A_W-1)'(-a_s2) : (A_W-1)'(a_s2);
	assign ta_prod = 66'(t_s2) * 66'(abs_a);

	// a < 0 and p < q with nonzero energy leaves a negative discriminant
	always_comb begin
		inner_nx = '0;
		noroot_nx = 1'b0;
		if (!a_s3[A_W-1]) begin
			inner_nx = p_s3 + INNER_W'(q_s3);
		end else if (p_s3 >= INNER_W'(q_s3)) begin
			inner_nx = p_s3 - INNER_W'(q_s3);
		end else begin
			noroot_nx = (e2_s3 != '0);
		end
		meta_nx.degen = (a_s3 == '0);
		meta_nx.noroot = noroot_nx;
		meta_nx.b = b_s3;
		meta_nx.a = a_s3;
	end

	always_ff @(posedge clk) begin
		mw2_s1 <= 24'(w_mass_q) * 24'(w_mass_q);
		pxmx_s1 <= 34'(lepton_px) * 34'(met_x);
		pymy_s1 <= 34'(lepton_py) * 34'(met_y);
		pz2_s1 <= 33'(34'(lepton_pz) * 34'(lepton_pz));
		mx2_s1 <= 33'(34'(met_x) * 34'(met_x));
		my2_s1 <= 33'(34'(met_y) * 34'(met_y));
		e2_s1 <= 32'(lepton_energy) * 32'(lepton_energy);
		pz_s1 <= lepton_pz;

		alpha_s2 <= $signed({12'd0, mw2_s1}) + $signed({pq_sum, 1'b0});
		a_s2 <= $signed({1'b0, pz2_s1}) - $signed({2'b00, e2_s1});
		t_s2 <= {1'b0, mx2_s1} + {1'b0, my2_s1};
		e2_s2 <= e2_s1;
		pz_s2 <= pz_s1;

		b_s3 <= B_W'(alpha_s2) * B_W'(pz_s2);
		p_s3 <= INNER_W'(abs_alpha) * INNER_W'(abs_alpha);
		q_s3 <= {ta_prod, 2'b00};
		a_s3 <= a_s2;
		e2_s3 <= e2_s2;

		inner_s4 <= inner_nx;
		e2_s4 <= e2_s3;
		meta_s4 <= meta_nx;

		pp0_s5 <= 67'(e2_s4) * 67'(inner_s4[HALF_W-1:0]);
		pp1_s5 <= 67'(e2_s4) * 67'(inner_s4[INNER_W-1:HALF_W]);
		meta_s5 <= meta_s4;

		rad_s6 <= RAD_W'(pp0_s5) + {pp1_s5, {HALF_W{1'b0}}};
		meta_s6 <= meta_s5;
	end

	npz_sqrt_pipe u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s6),
		.in_rad(rad_s6),
		.in_meta(meta_s6),
		.out_valid(sq_valid),
		.out_root(sq_root),
		.out_meta(sq_meta)
	);

	assign nb = -NUMS_W'(sq_meta.b);
	assign s_eff = (sq_root < ROOT_W'(S_THRESH)) ? '0 : sq_root;

	always_comb begin
		if (sq_meta.degen) status_nx = ST_DEGEN;
		else if (sq_meta.noroot) status_nx = ST_NONE;
		else if (s_eff == '0) status_nx = ST_ONE;
		else status_nx = ST_TWO;
	end

	// a zero root gives equal numerators, so the single root falls out alike
	always_ff @(posedge clk) begin
		num1_s7 <= nb + $signed({{(NUMS_W-ROOT_W){1'b0}}, s_eff});
		num2_s7 <= nb - $signed({{(NUMS_W-ROOT_W){1'b0}}, s_eff});
		den_s7 <= {sq_meta.a, 1'b0};
		status_s7 <= status_nx;
	end

	npz_div_pipe u_div_first (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s7),
		.in_num(num1_s7),
		.in_den(den_s7),
		.out_valid(d1_valid),
		.out_quot(d1_quot)
	);

	npz_div_pipe u_div_second (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s7),
		.in_num(num2_s7),
		.in_den(den_s7),
		.out_valid(d2_valid),
		.out_quot(d2_quot)
	);

	always_ff @(posedge clk) begin
		stat_d[0] <= status_s7;
		for (int k = 1; k < DIV_LAT; k++) stat_d[k] <= stat_d[k-1];
	end

	always_comb begin
		s1f = 1'b0;
		s2f = 1'b0;
		if (d1_quot > ROOT_MAX) begin
			c1 = ROOT_MAX[OUT_W-1:0];
			s1f = 1'b1;
		end else if (d1_quot < ROOT_MIN) begin
			c1 = ROOT_MIN[OUT_W-1:0];
			s1f = 1'b1;
		end else begin
			c1 = d1_quot[OUT_W-1:0];
		end
		if (d2_quot > ROOT_MAX) begin
			c2 = ROOT_MAX[OUT_W-1:0];
			s2f = 1'b1;
		end else if (d2_quot < ROOT_MIN) begin
			c2 = ROOT_MIN[OUT_W-1:0];
			s2f = 1'b1;
		end else begin
			c2 = d2_quot[OUT_W-1:0];
		end
		roots = d2_valid && ((stat_d[DIV_LAT-1] == ST_ONE) || (stat_d[DIV_LAT-1] == ST_TWO));
	end

	always_ff @(posedge clk) begin
		status_q <= stat_d[DIV_LAT-1];
		first_q <= roots ? c1 : '0;
		second_q <= roots ? c2 : '0;
		sat_q <= roots && (s1f || s2f);
	end

	assign result_valid = result_valid_q;
	assign root_status = status_q;
	assign pz_first = first_q;
	assign pz_second = second_q;
	assign saturated = sat_q;

endmodule
